// ===== rtl/aweacc_pkg.sv =====
// ----------------------------------------------------------------------------
// aweacc_pkg
// Shared types, command codes and filter coefficients of the A-weighted
// energy accumulator.
// ----------------------------------------------------------------------------
package aweacc_pkg;

  localparam int MAX_SECTIONS = 6;
  localparam int COEF_IDX_W   = 3;
  localparam int SUM_W        = 63;
  localparam int WIN_W        = 16;
  localparam logic [WIN_W-1:0] WIN_RESET = 16'd16000;
  localparam logic signed [15:0] DC_WEIGHT = 16'sd26844;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DC_MUL,
    OP_DC_UPD,
    OP_X_CALC,
    OP_F_MUL,
    OP_F_ACC,
    OP_S_B0,
    OP_S_Y,
    OP_S_B1,
    OP_S_A1,
    OP_S_B2,
    OP_S_A2,
    OP_W_MUL,
    OP_W_ACC,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [COEF_IDX_W-1:0] sec;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
  } coef_t;

  localparam coef_t COEFS [MAX_SECTIONS] = '{
    '{ 32'sd142027321, -32'sd284054641, 32'sd142027321, -32'sd532545611,  32'sd264127604},
    '{ 32'sd268435456, -32'sd536870912, 32'sd268435456, -32'sd457819355,  32'sd192196565},
    '{ 32'sd268435456,  32'sd536870912, 32'sd268435456,  32'sd220536907,  32'sd45296336},
    '{ 32'sd268435456,  32'sd0,         32'sd0,          32'sd0,          32'sd0},
    '{ 32'sd268435456,  32'sd0,         32'sd0,          32'sd0,          32'sd0},
    '{ 32'sd268435456,  32'sd0,         32'sd0,          32'sd0,          32'sd0}
  };

endpackage

// ===== rtl/aweacc_ctrl.sv =====
// ----------------------------------------------------------------------------
// aweacc_ctrl
// Sequencer: steps the datapath through DC removal, the biquad cascade, both
// squares and window bookkeeping; one command per cycle save idle/finish waits.
// ----------------------------------------------------------------------------
module aweacc_ctrl #(
  parameter int SECTIONS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              fin_ready,
  output aweacc_pkg::cmd_t  cmd
);

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DC_MUL,
    ST_DC_UPD,
    ST_X_CALC,
    ST_F_MUL,
    ST_F_ACC,
    ST_S_B0,
    ST_S_Y,
    ST_S_B1,
    ST_S_A1,
    ST_S_B2,
    ST_S_A2,
    ST_W_MUL,
    ST_W_ACC,
    ST_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [SEC_W-1:0] sec_r, sec_nxt;
  logic             ready_r, ready_nxt;
  aweacc_pkg::op_t  op;

  always_comb begin
    state_nxt = state_r;
    sec_nxt   = sec_r;
    ready_nxt = ready_r;
    op        = aweacc_pkg::OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op        = aweacc_pkg::OP_LOAD;
          state_nxt = ST_DC_MUL;
          ready_nxt = 1'b0;
        end
      end
      ST_DC_MUL: begin
        op        = aweacc_pkg::OP_DC_MUL;
        state_nxt = ST_DC_UPD;
      end
      ST_DC_UPD: begin
        op        = aweacc_pkg::OP_DC_UPD;
        state_nxt = ST_X_CALC;
      end
      ST_X_CALC: begin
        op        = aweacc_pkg::OP_X_CALC;
        state_nxt = ST_F_MUL;
      end
      ST_F_MUL: begin
        op        = aweacc_pkg::OP_F_MUL;
        state_nxt = ST_F_ACC;
      end
      ST_F_ACC: begin
        op        = aweacc_pkg::OP_F_ACC;
        state_nxt = ST_S_B0;
        sec_nxt   = '0;
      end
      ST_S_B0: begin
        op        = aweacc_pkg::OP_S_B0;
        state_nxt = ST_S_Y;
      end
      ST_S_Y: begin
        op        = aweacc_pkg::OP_S_Y;
        state_nxt = ST_S_B1;
      end
      ST_S_B1: begin
        op        = aweacc_pkg::OP_S_B1;
        state_nxt = ST_S_A1;
      end
      ST_S_A1: begin
        op        = aweacc_pkg::OP_S_A1;
        state_nxt = ST_S_B2;
      end
      ST_S_B2: begin
        op        = aweacc_pkg::OP_S_B2;
        state_nxt = ST_S_A2;
      end
      ST_S_A2: begin
        op = aweacc_pkg::OP_S_A2;
        if (sec_r == SEC_LAST) begin
          state_nxt = ST_W_MUL;
        end else begin
          state_nxt = ST_S_B0;
          sec_nxt   = sec_r + 1'b1;
        end
      end
      ST_W_MUL: begin
        op        = aweacc_pkg::OP_W_MUL;
        state_nxt = ST_W_ACC;
      end
      ST_W_ACC: begin
        op        = aweacc_pkg::OP_W_ACC;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_ready) begin
          op        = aweacc_pkg::OP_FINISH;
          state_nxt = ST_IDLE;
          ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sec_r   <= '0;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      sec_r   <= sec_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign in_tready = ready_r;
  assign cmd.op    = op;
  assign cmd.sec   = aweacc_pkg::COEF_IDX_W'(sec_r);

endmodule

// ===== rtl/aweacc_dp.sv =====
// ----------------------------------------------------------------------------
// aweacc_dp
// Datapath: DC tracker, one shared 32x32 multiplier with product register,
// biquad delay registers, saturating energy sums, window counter and the
// result register.
// ----------------------------------------------------------------------------
module aweacc_dp #(
  parameter int SECTIONS    = 3,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  aweacc_pkg::cmd_t                    cmd,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic                                cfg_wr_en,
  input  logic [aweacc_pkg::WIN_W-1:0]        cfg_wr_data,
  output logic                                fin_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [aweacc_pkg::SUM_W-1:0]        out_weighted,
  output logic [aweacc_pkg::SUM_W-1:0]        out_flat,
  output logic                                out_silent
);

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int SHIFT = 32 - SAMPLE_BITS;
  localparam int SUM_W = aweacc_pkg::SUM_W;
  localparam int WIN_W = aweacc_pkg::WIN_W;
  localparam logic signed [47:0] S40_MAX = 48'sd549755813887;
  localparam logic signed [47:0] S40_MIN = -48'sd549755813888;
  localparam logic signed [47:0] S32_MAX = 48'sd2147483647;
  localparam logic signed [47:0] S32_MIN = -48'sd2147483648;

  function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
    logic signed [39:0] r;
    if (v > S40_MAX) begin
      r = S40_MAX[39:0];
    end else if (v < S40_MIN) begin
      r = S40_MIN[39:0];
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [43:0] rnd20(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd524288;
    t = t >>> 20;
    return t[43:0];
  endfunction

  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic signed [39:0]            dc_r;
  logic signed [56:0]            dcp_r;
  logic signed [31:0]            x_r;
  logic signed [31:0]            y_r;
  logic signed [63:0]            prod_r;
  logic signed [63:0]            acc_r;
  logic signed [39:0]            z_r [SECTIONS][2];
  logic [SUM_W-1:0]              fsum_r;
  logic [SUM_W-1:0]              wsum_r;
  logic [WIN_W-1:0]              cnt_r;
  logic [WIN_W-1:0]              window_r;
  logic                          out_valid_r;
  logic [SUM_W-1:0]              out_weighted_r;
  logic [SUM_W-1:0]              out_flat_r;
  logic                          out_silent_r;

  logic signed [31:0]            s31;
  logic signed [40:0]            dc_diff;
  logic signed [56:0]            dc_prod;
  logic signed [57:0]            dc_t;
  logic signed [29:0]            dc_rnd;
  logic signed [41:0]            dc_sum;
  logic signed [41:0]            x_t;
  logic signed [33:0]            x_rnd;
  logic signed [43:0]            y_r1;
  logic signed [45:0]            y_t;
  logic signed [37:0]            y_rnd;
  logic signed [45:0]            z0_sum;
  logic signed [31:0]            mul_a;
  logic signed [31:0]            mul_b;
  logic signed [63:0]            prod_nxt;
  logic [SUM_W:0]                sq_sum;
  logic [SUM_W-1:0]              sq_sat;
  logic [WIN_W:0]                cnt_inc;
  logic [WIN_W:0]                need;
  logic                          win_done;
  logic [SEC_W-1:0]              sec;
  aweacc_pkg::coef_t             coef;

  assign sec  = cmd.sec[SEC_W-1:0];
  assign coef = aweacc_pkg::COEFS[cmd.sec];

  assign s31     = 32'(samp_r) <<< SHIFT;
  assign dc_diff = 41'(s31) - 41'(dc_r);
  assign dc_prod = dc_diff * aweacc_pkg::DC_WEIGHT;
  assign dc_t    = 58'(dcp_r) + 58'sd134217728;
  assign dc_rnd  = 30'(dc_t >>> 28);
  assign dc_sum  = 42'(dc_r) + 42'(dc_rnd);

  assign x_t   = 42'(dc_diff) + 42'sd128;
  assign x_rnd = 34'(x_t >>> 8);

  assign y_r1  = rnd20(prod_r);
  assign y_t   = 46'(y_r1) + 46'(z_r[sec][0]) + 46'sd128;
  assign y_rnd = 38'(y_t >>> 8);

  assign z0_sum = 46'(rnd20(acc_r)) + 46'(z_r[sec][1]);

  always_comb begin
    mul_a = x_r;
    mul_b = x_r;
    case (cmd.op)
      aweacc_pkg::OP_S_B0: mul_b = coef.b0;
      aweacc_pkg::OP_S_Y:  mul_b = coef.b1;
      aweacc_pkg::OP_S_B1: begin
        mul_a = y_r;
        mul_b = coef.a1;
      end
      aweacc_pkg::OP_S_A1: mul_b = coef.b2;
      aweacc_pkg::OP_S_B2: begin
        mul_a = y_r;
        mul_b = coef.a2;
      end
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  assign sq_sum = ((cmd.op == aweacc_pkg::OP_W_ACC) ? {1'b0, wsum_r} : {1'b0, fsum_r})
                  + prod_r[SUM_W:0];
  assign sq_sat = sq_sum[SUM_W] ? {SUM_W{1'b1}} : sq_sum[SUM_W-1:0];

  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;
  assign need     = (window_r == '0) ? (WIN_W+1)'(1) : {1'b0, window_r};
  assign win_done = (cnt_inc >= need);

  assign fin_ready = !win_done || !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    case (cmd.op)
      aweacc_pkg::OP_LOAD:   samp_r <= sample;
      aweacc_pkg::OP_DC_MUL: dcp_r  <= dc_prod;
      aweacc_pkg::OP_X_CALC: x_r    <= sat32(48'(x_rnd));
      aweacc_pkg::OP_F_MUL,
      aweacc_pkg::OP_W_MUL,
      aweacc_pkg::OP_S_B0:   prod_r <= prod_nxt;
      aweacc_pkg::OP_S_Y: begin
        y_r    <= sat32(48'(y_rnd));
        prod_r <= prod_nxt;
      end
      aweacc_pkg::OP_S_B1: begin
        acc_r  <= prod_r;
        prod_r <= prod_nxt;
      end
      aweacc_pkg::OP_S_A1: begin
        acc_r  <= acc_r - prod_r;
        prod_r <= prod_nxt;
      end
      aweacc_pkg::OP_S_B2: begin
        acc_r  <= prod_r;
        prod_r <= prod_nxt;
      end
      aweacc_pkg::OP_S_A2:   x_r    <= y_r;
      default: ;
    endcase
    if (cmd.op == aweacc_pkg::OP_FINISH && win_done) begin
      out_weighted_r <= wsum_r;
      out_flat_r     <= fsum_r;
      out_silent_r   <= (wsum_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r        <= '0;
      fsum_r      <= '0;
      wsum_r      <= '0;
      cnt_r       <= '0;
      window_r    <= aweacc_pkg::WIN_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SECTIONS; i++) begin
        z_r[i][0] <= '0;
        z_r[i][1] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      if (cmd.op == aweacc_pkg::OP_FINISH && win_done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        aweacc_pkg::OP_DC_UPD: dc_r   <= sat40(48'(dc_sum));
        aweacc_pkg::OP_F_ACC:  fsum_r <= sq_sat;
        aweacc_pkg::OP_W_ACC:  wsum_r <= sq_sat;
        aweacc_pkg::OP_S_B2:   z_r[sec][0] <= sat40(48'(z0_sum));
        aweacc_pkg::OP_S_A2:   z_r[sec][1] <= sat40(48'(rnd20(acc_r - prod_r)));
        aweacc_pkg::OP_FINISH: begin
          if (win_done) begin
            fsum_r <= '0;
            wsum_r <= '0;
            cnt_r  <= '0;
          end else begin
            cnt_r <= cnt_inc[WIN_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_weighted = out_weighted_r;
  assign out_flat     = out_flat_r;
  assign out_silent   = out_silent_r;

endmodule

// ===== rtl/a_weighted_energy_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// a_weighted_energy_accumulator_core
// One sample at a time: in_tready stays low until the current sample's sequence
// ends; a single shared 32x32 multiplier serves the filter and square products.
// A result appears on out_tvalid only for the sample that completes a window.
// Synchronous active-low reset clears the DC tracker, filter delays, sums,
// counter and result valid; window_length returns to 16000.
// ----------------------------------------------------------------------------
module a_weighted_energy_accumulator_core #(
  parameter int SECTIONS    = 3,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,  // sample
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [127:0]                            out_tdata,  // weighted_energy, flat_energy
  output logic                                    out_tuser,  // silent
  input  logic                                    cfg_wr_en,
  input  logic [aweacc_pkg::WIN_W-1:0]            cfg_wr_data
);

  localparam int SUM_W = aweacc_pkg::SUM_W;

  aweacc_pkg::cmd_t  cmd;
  logic              fin_ready;
  logic [SUM_W-1:0]  out_weighted;
  logic [SUM_W-1:0]  out_flat;

  aweacc_ctrl #(
    .SECTIONS (SECTIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .fin_ready (fin_ready),
    .cmd       (cmd)
  );

  aweacc_dp #(
    .SECTIONS    (SECTIONS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sample       (in_tdata[SAMPLE_BITS-1:0]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fin_ready    (fin_ready),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_weighted (out_weighted),
    .out_flat     (out_flat),
    .out_silent   (out_tuser)
  );

  assign out_tdata = {2'b00, out_flat, out_weighted};

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the A-weighted energy accumulator core. A bit-exact
// fixed-point model of the DC tracker, the three A-weighting biquads and the
// saturating window sums predicts each window result, which is compared with
// the result stream. Stimulus is a short directed pass (extremes, silent
// input, zero window, window shortened below the running count) followed by
// randomized windows of noise, square waves and small signals, with random
// stalls on both streams and one long output back-pressure stretch.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 8;
  localparam int ITEM_TARGET = 1450;
  localparam int CALM_ITEMS  = 150;
  localparam int SETTLE      = 40;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 500000;

  typedef logic signed [127:0] wide_t;

  localparam wide_t SUM_MAX = (wide_t'(1) << 63) - 1;
  localparam wide_t DC_GAIN = 26844;

  localparam longint CB0 [3] = '{142027321, 268435456, 268435456};
  localparam longint CB1 [3] = '{-284054641, -536870912, 536870912};
  localparam longint CB2 [3] = '{142027321, 268435456, 268435456};
  localparam longint CA1 [3] = '{-532545611, -457819355, 220536907};
  localparam longint CA2 [3] = '{264127604, 192196565, 45296336};

  localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S_MIN = 24'sh800000;

  localparam logic signed [23:0] EDGE_SAMPLES [11] = '{
    24'sd0, 24'sd0, S_MAX, S_MIN, S_MAX, S_MIN, -24'sd1, 24'sd1,
    24'sh555555, 24'shAAAAAA, 24'sd0
  };

  typedef enum {KIND_NOISE, KIND_SQUARE, KIND_SMALL} phase_kind_t;

  typedef struct {
    logic [62:0] weighted;
    logic [62:0] flat;
    logic        silent;
  } window_result_t;

  class energy_scoreboard;
    wide_t          dc_est;
    wide_t          delay [6];
    wide_t          weighted_acc;
    wide_t          flat_acc;
    int unsigned    count;
    logic [15:0]    window_len;
    window_result_t results_due [$];
    int             mismatches;
    int             windows_checked;
    int             silent_windows;

    function new();
      dc_est = 0;
      foreach (delay[i]) delay[i] = 0;
      weighted_acc = 0;
      flat_acc = 0;
      count = 0;
      window_len = 16'd16000;
      mismatches = 0;
      windows_checked = 0;
      silent_windows = 0;
    endfunction

    function wide_t rnd(wide_t v, int n);
      return (v + (wide_t'(1) << (n - 1))) >>> n;
    endfunction

    function wide_t sat(wide_t v, int bits);
      wide_t hi;
      hi = (wide_t'(1) << (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function wide_t add_square(wide_t acc, wide_t v);
      wide_t s;
      s = acc + v * v;
      if (s > SUM_MAX) s = SUM_MAX;
      return s;
    endfunction

    function void note_sample(logic signed [23:0] sample);
      wide_t          s31;
      wide_t          x;
      wide_t          y;
      window_result_t r;
      int unsigned    need;
      int             k;
      s31 = wide_t'(sample) <<< 8;
      dc_est = sat(dc_est + rnd((s31 - dc_est) * DC_GAIN, 28), 40);
      x = sat(rnd(s31 - dc_est, 8), 32);
      flat_acc = add_square(flat_acc, x);
      for (k = 0; k < 3; k++) begin
        y = sat(rnd(rnd(x * CB0[k], 20) + delay[2*k], 8), 32);
        delay[2*k]   = sat(rnd(x * CB1[k] - y * CA1[k], 20) + delay[2*k+1], 40);
        delay[2*k+1] = sat(rnd(x * CB2[k] - y * CA2[k], 20), 40);
        x = y;
      end
      weighted_acc = add_square(weighted_acc, x);
      need = (window_len == 0) ? 1 : window_len;
      count++;
      if (count >= need) begin
        r.weighted = weighted_acc[62:0];
        r.flat     = flat_acc[62:0];
        r.silent   = (weighted_acc == 0);
        results_due.push_back(r);
        weighted_acc = 0;
        flat_acc = 0;
        count = 0;
      end
    endfunction

    function void check_result(logic [62:0] weighted, logic [62:0] flat, logic silent);
      window_result_t e;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: unexpected result weighted=%0d flat=%0d silent=%0b",
                   $realtime, weighted, flat, silent);
        return;
      end
      e = results_due.pop_front();
      windows_checked++;
      if (e.silent) silent_windows++;
      if (weighted !== e.weighted || flat !== e.flat || silent !== e.silent) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: window %0d exp w=%0d f=%0d s=%0b got w=%0d f=%0d s=%0b",
                   $realtime, windows_checked, e.weighted, e.flat, e.silent,
                   weighted, flat, silent);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [23:0]                  in_tdata;   // sample
  logic                         out_tvalid;
  logic                         out_tready;
  logic [127:0]                 out_tdata;  // weighted_energy, flat_energy
  logic                         out_tuser;  // silent
  logic                         cfg_wr_en;
  logic [aweacc_pkg::WIN_W-1:0] cfg_wr_data;

  energy_scoreboard sb = new();

  bit  calm = 1'b0;
  bit  long_hold = 1'b0;
  int  samples_sent = 0;
  int  settings_used = 0;
  int  cycles = 0;

  a_weighted_energy_accumulator_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("a_weighted_energy_accumulator_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_sample(in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[62:0], out_tdata[125:63], out_tuser);
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        stall_left = LONG_HOLD;
        long_hold = 1'b0;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(logic signed [23:0] s);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // drop valid, wait for the last window result, then let the pipeline settle
  task automatic finish_phase();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(logic [15:0] len);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.window_len = len;
    settings_used++;
  endtask

  function automatic logic signed [23:0] noise_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return S_MAX;
      2:       return S_MIN;
      3, 4:    return 24'($signed($urandom_range(0, 511)) - 256);
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    phase_kind_t kind;
    int          n;
    int          half;
    int          pick;
    logic [15:0] len;
    logic signed [23:0] s;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero window behaves as one sample per window
    write_window(16'd0);
    foreach (EDGE_SAMPLES[i]) send_sample(EDGE_SAMPLES[i]);
    finish_phase();

    // longest window, then shorten it below the running count
    write_window(16'hFFFF);
    repeat (8) send_sample($urandom_range(0, 1) ? S_MAX : S_MIN);
    finish_phase();
    write_window(16'd3);
    repeat (4) send_sample(noise_sample());
    finish_phase();

    // hold off the result side so the core backs up its input
    write_window(16'd1);
    long_hold = 1'b1;
    repeat (30) send_sample(noise_sample());
    finish_phase();

    while (samples_sent < ITEM_TARGET) begin
      if (samples_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick == 0)      len = 16'd0;
      else if (pick < 3)  len = 16'd1;
      else if (pick < 13) len = 16'($urandom_range(2, 16));
      else if (pick < 18) len = 16'($urandom_range(17, 64));
      else                len = 16'($urandom_range(100, 300));
      write_window(len);
      kind = phase_kind_t'($urandom_range(0, 2));
      n    = $urandom_range(10, 60);
      half = $urandom_range(1, 40);
      for (int i = 0; i < n; i++) begin
        case (kind)
          KIND_SQUARE: s = ((i / half) % 2) ? S_MAX : S_MIN;
          KIND_SMALL:  s = 24'($signed($urandom_range(0, 63)) - 32);
          default:     s = noise_sample();
        endcase
        send_sample(s);
      end
      finish_phase();
    end

    $display("Run covered %0d samples over %0d window settings.", samples_sent, settings_used);
    $display("Checked %0d window results, %0d of them silent.",
             sb.windows_checked, sb.silent_windows);
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("a_weighted_energy_accumulator_core verification clean");
    end else begin
      $display("a_weighted_energy_accumulator_core verification failed");
    end
    $finish;
  end

endmodule
